// ----- rtl/price_level_order_book_macros.svh -----
// assertion macros for the price level order book
// used by plob_back, no other dependencies
`ifndef PRICE_LEVEL_ORDER_BOOK_MACROS_SVH
`define PRICE_LEVEL_ORDER_BOOK_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define PLOB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true out of reset
`define PLOB_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PLOB_ASSERT(lbl, clk, rst_n, prop, msg)
`define PLOB_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- rtl/plob_pkg.sv -----
// shared types and codes for the price level order book
// no dependencies
package plob_pkg;

    localparam int PRICE_W = 48;
    localparam int SIZE_W  = 48;

    // action codes
    localparam logic [1:0] ACT_UPDATE = 2'd0;
    localparam logic [1:0] ACT_CLEAR  = 2'd1;
    localparam logic [1:0] ACT_SNAP   = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    // update status codes
    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_REMOVED = 2'd1;
    localparam logic [1:0] ST_ABSENT  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_LEVEL  = 1'b1;

    typedef logic [PRICE_W-1:0] price_t;
    typedef logic [SIZE_W-1:0]  size_t;

    typedef struct packed {
        logic [1:0] action;
        logic       side;
        price_t     price;
        size_t      size;
    } item_t;

    // per-side controls from the back end
    typedef struct packed {
        logic clear;
        logic apply;
    } side_ctl_t;

endpackage

// ----- rtl/plob_front.sv -----
// front end: accepts items, drops unused action codes, two-entry queue
// depends on plob_pkg
module plob_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       action,
    input  logic             side,
    input  plob_pkg::price_t price,
    input  plob_pkg::size_t  size,
    output logic             busy,
    output plob_pkg::item_t  head,
    output logic             empty,
    input  logic             pop
);
    import plob_pkg::*;

    item_t      q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       do_pop;

    // classify: only real actions enter the queue
    assign busy   = (cnt_reg == 2'd2);
    assign empty  = (cnt_reg == 2'd0);
    assign push   = start && !busy && (action != ACT_NONE);
    assign do_pop = pop && !empty;
    assign head   = q_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{action: action, side: side, price: price, size: size};
        end
    end

endmodule

// ----- rtl/plob_book_side.sv -----
// one side of the book: sorted chain of level cells with parallel compare
// depends on plob_pkg
module plob_book_side #(
    parameter int   LEVELS    = 64,
    parameter int   TOP_DEPTH = 5,
    parameter logic IS_ASK    = 1'b0,
    localparam int  CW        = $clog2(LEVELS + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  plob_pkg::side_ctl_t ctl,
    input  plob_pkg::price_t    price,
    input  plob_pkg::size_t     size,
    output logic                found,
    output logic                full,
    output logic [CW-1:0]       count,
    output plob_pkg::price_t    top_price [TOP_DEPTH],
    output plob_pkg::size_t     top_size [TOP_DEPTH]
);
    import plob_pkg::*;

    price_t          cell_price_reg [LEVELS];
    size_t           cell_size_reg [LEVELS];
    logic [LEVELS-1:0] ahead_reg;
    logic [LEVELS-1:0] ahead_next;
    logic [LEVELS-1:0] eq_reg;
    logic [LEVELS-1:0] eq_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_remove;
    logic            do_write;
    logic            do_insert;

    // per-cell compare against the item price
    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            ahead_next[i] = (CW'(i) < count_reg) &&
                            (IS_ASK ? (cell_price_reg[i] < price)
                                    : (cell_price_reg[i] > price));
            eq_next[i]    = (CW'(i) < count_reg) && (cell_price_reg[i] == price);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ahead_reg <= '0;
            eq_reg    <= '0;
        end
        else
        begin
            ahead_reg <= ahead_next;
            eq_reg    <= eq_next;
        end
    end

    assign found = |eq_reg;
    assign full  = (count_reg == CW'(LEVELS));
    assign count = count_reg;

    // operation decode on the registered compare
    assign do_remove = ctl.apply && (size == '0) && found;
    assign do_write  = ctl.apply && (size != '0) && found;
    assign do_insert = ctl.apply && (size != '0) && !found && !full;

    // level count
    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (do_remove)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (do_insert)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // cell chain: shift up on remove, down on insert, size written in place on update
    for (genvar i = 0; i < LEVELS; i++)
    begin : g_cell
        logic prev_ahead;
        if (i == 0)
        begin : g_first
            assign prev_ahead = 1'b1;
        end
        else
        begin : g_rest
            assign prev_ahead = ahead_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (do_remove && !ahead_reg[i])
            begin
                if (i < LEVELS - 1)
                begin
                    cell_price_reg[i] <= cell_price_reg[(i < LEVELS - 1) ? i + 1 : i];
                    cell_size_reg[i]  <= cell_size_reg[(i < LEVELS - 1) ? i + 1 : i];
                end
            end
            else if (do_write && eq_reg[i])
            begin
                cell_size_reg[i] <= size;
            end
            else if (do_insert)
            begin
                if (!ahead_reg[i] && prev_ahead)
                begin
                    cell_price_reg[i] <= price;
                    cell_size_reg[i]  <= size;
                end
                else if (!prev_ahead)
                begin
                    cell_price_reg[i] <= cell_price_reg[(i > 0) ? i - 1 : 0];
                    cell_size_reg[i]  <= cell_size_reg[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end

    // best levels at fixed cells
    for (genvar r = 0; r < TOP_DEPTH; r++)
    begin : g_top
        if (r < LEVELS)
        begin : g_have
            assign top_price[r] = cell_price_reg[r];
            assign top_size[r]  = cell_size_reg[r];
        end
        else
        begin : g_none
            assign top_price[r] = '0;
            assign top_size[r]  = '0;
        end
    end

endmodule

// ----- rtl/plob_back.sv -----
// back end: sequencer that runs updates, clears and snapshots on both sides
// depends on plob_pkg, plob_book_side and the assertion macro header
`include "price_level_order_book_macros.svh"
module plob_back #(
    parameter int LEVELS    = 64,
    parameter int TOP_DEPTH = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  plob_pkg::item_t  head,
    input  logic             empty,
    output logic             pop,
    output logic             strobe,
    output logic             kind,
    output logic [1:0]       status,
    output logic             level_side,
    output logic [3:0]       rank,
    output plob_pkg::price_t level_price,
    output plob_pkg::size_t  level_size,
    output logic             last
);
    import plob_pkg::*;

    localparam int CW  = $clog2(LEVELS + 1);
    localparam int RKW = (TOP_DEPTH > 1) ? $clog2(TOP_DEPTH) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;
    localparam logic [1:0] S_SNAP  = 2'd3;

    logic [1:0]     state_reg;
    logic [1:0]     state_next;
    item_t          cur_reg;
    item_t          cur_next;
    logic           snap_side_reg;
    logic           snap_side_next;
    logic [RKW-1:0] snap_rank_reg;
    logic [RKW-1:0] snap_rank_next;
    logic           snap_last;
    logic           can_take;

    side_ctl_t      bid_ctl;
    side_ctl_t      ask_ctl;
    logic           bid_found;
    logic           bid_full;
    logic [CW-1:0]  bid_count;
    logic           ask_found;
    logic           ask_full;
    logic [CW-1:0]  ask_count;
    price_t         bid_top_price [TOP_DEPTH];
    size_t          bid_top_size [TOP_DEPTH];
    price_t         ask_top_price [TOP_DEPTH];
    size_t          ask_top_size [TOP_DEPTH];

    logic           sel_found;
    logic           sel_full;
    logic [1:0]     upd_status;
    logic [CW-1:0]  snap_count;
    price_t         snap_price;
    size_t          snap_size;
    logic           snap_have;

    logic           strobe_reg;
    logic           kind_reg;
    logic [1:0]     status_reg;
    logic           side_reg;
    logic [3:0]     rank_reg;
    price_t         price_reg;
    size_t          size_reg;
    logic           last_reg;

    // the two book sides
    plob_book_side #(.LEVELS(LEVELS), .TOP_DEPTH(TOP_DEPTH), .IS_ASK(1'b0)) u_bid (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (bid_ctl),
        .price     (cur_reg.price),
        .size      (cur_reg.size),
        .found     (bid_found),
        .full      (bid_full),
        .count     (bid_count),
        .top_price (bid_top_price),
        .top_size  (bid_top_size)
    );

    plob_book_side #(.LEVELS(LEVELS), .TOP_DEPTH(TOP_DEPTH), .IS_ASK(1'b1)) u_ask (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ask_ctl),
        .price     (cur_reg.price),
        .size      (cur_reg.size),
        .found     (ask_found),
        .full      (ask_full),
        .count     (ask_count),
        .top_price (ask_top_price),
        .top_size  (ask_top_size)
    );

    // dispatch point: idle, end of an update, or end of a snapshot
    assign snap_last = snap_side_reg && (snap_rank_reg == RKW'(TOP_DEPTH - 1));
    assign can_take  = (state_reg == S_IDLE) || (state_reg == S_APPLY) ||
                       ((state_reg == S_SNAP) && snap_last);
    assign pop       = can_take && !empty;

    // side controls
    always_comb
    begin
        bid_ctl.clear = pop && (head.action == ACT_CLEAR);
        ask_ctl.clear = pop && (head.action == ACT_CLEAR);
        bid_ctl.apply = (state_reg == S_APPLY) && !cur_reg.side;
        ask_ctl.apply = (state_reg == S_APPLY) && cur_reg.side;
    end

    // update status
    assign sel_found = cur_reg.side ? ask_found : bid_found;
    assign sel_full  = cur_reg.side ? ask_full : bid_full;
    always_comb
    begin
        if (cur_reg.size == '0)
        begin
            upd_status = sel_found ? ST_REMOVED : ST_ABSENT;
        end
        else
        begin
            upd_status = (sel_found || !sel_full) ? ST_STORED : ST_FULL;
        end
    end

    // snapshot level select
    assign snap_count = snap_side_reg ? ask_count : bid_count;
    assign snap_have  = (int'(snap_rank_reg) < int'(snap_count));
    assign snap_price = !snap_have ? '0 :
                        (snap_side_reg ? ask_top_price[snap_rank_reg]
                                       : bid_top_price[snap_rank_reg]);
    assign snap_size  = !snap_have ? '0 :
                        (snap_side_reg ? ask_top_size[snap_rank_reg]
                                       : bid_top_size[snap_rank_reg]);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        snap_side_next = snap_side_reg;
        snap_rank_next = snap_rank_reg;
        case (state_reg)
            S_CMP:
            begin
                state_next = S_APPLY;
            end
            S_SNAP:
            begin
                if (!snap_last)
                begin
                    if (snap_rank_reg == RKW'(TOP_DEPTH - 1))
                    begin
                        snap_rank_next = '0;
                        snap_side_next = 1'b1;
                    end
                    else
                    begin
                        snap_rank_next = snap_rank_reg + RKW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (can_take)
        begin
            state_next = S_IDLE;
            if (!empty)
            begin
                cur_next = head;
                case (head.action)
                    ACT_UPDATE:
                    begin
                        state_next = S_CMP;
                    end
                    ACT_SNAP:
                    begin
                        state_next     = S_SNAP;
                        snap_side_next = 1'b0;
                        snap_rank_next = '0;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            snap_side_reg <= 1'b0;
            snap_rank_reg <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            snap_side_reg <= snap_side_next;
            snap_rank_reg <= snap_rank_next;
            strobe_reg    <= (state_reg == S_APPLY) || (state_reg == S_SNAP);
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (state_reg == S_APPLY)
        begin
            kind_reg   <= KIND_STATUS;
            status_reg <= upd_status;
            side_reg   <= cur_reg.side;
            rank_reg   <= 4'd0;
            price_reg  <= cur_reg.price;
            size_reg   <= cur_reg.size;
            last_reg   <= 1'b1;
        end
        else
        begin
            kind_reg   <= KIND_LEVEL;
            status_reg <= ST_STORED;
            side_reg   <= snap_side_reg;
            rank_reg   <= 4'(snap_rank_reg);
            price_reg  <= snap_price;
            size_reg   <= snap_size;
            last_reg   <= snap_last;
        end
    end

    assign strobe      = strobe_reg;
    assign kind        = kind_reg;
    assign status      = status_reg;
    assign level_side  = side_reg;
    assign rank        = rank_reg;
    assign level_price = price_reg;
    assign level_size  = size_reg;
    assign last        = last_reg;

    // checks
    `PLOB_ASSERT_NEVER(a_bid_count_range, clk, rst_n, bid_count > CW'(LEVELS), "bid count over depth")
    `PLOB_ASSERT_NEVER(a_ask_count_range, clk, rst_n, ask_count > CW'(LEVELS), "ask count over depth")
    `PLOB_ASSERT(a_apply_after_cmp, clk, rst_n, state_reg == S_APPLY |-> $past(state_reg) == S_CMP, "apply without compare")
    `PLOB_ASSERT(a_status_is_last, clk, rst_n, strobe_reg && (kind_reg == KIND_STATUS) |-> last_reg, "update result not last")
    `PLOB_ASSERT(a_snap_last_ask, clk, rst_n, strobe_reg && (kind_reg == KIND_LEVEL) && last_reg |-> side_reg, "snapshot ends off ask side")

endmodule

// ----- rtl/price_level_order_book.sv -----
// Update: compare, then shift/apply in the back end, with a registered result.
// Snapshot: TOP_DEPTH levels per side, bid then ask, one level per cycle from the cell chain heads.
// Clear: resets both side counts when popped. A two-item queue takes items while the back end works.
// Results appear in the cycle after they are formed and cannot be stalled.
// Reset clears counts, queue and sequencer; level cells are undefined until written.
// depends on plob_pkg, plob_front, plob_back
module price_level_order_book #(
    parameter int LEVELS    = 64,
    parameter int TOP_DEPTH = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       action,
    input  logic             side,
    input  plob_pkg::price_t price,
    input  plob_pkg::size_t  size,
    output logic             busy,
    output logic             strobe,
    output logic             kind,
    output logic [1:0]       status,
    output logic             level_side,
    output logic [3:0]       rank,
    output plob_pkg::price_t level_price,
    output plob_pkg::size_t  level_size,
    output logic             last
);
    import plob_pkg::*;

    item_t head;
    logic  empty;
    logic  pop;

    // front end and queue
    plob_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .side   (side),
        .price  (price),
        .size   (size),
        .busy   (busy),
        .head   (head),
        .empty  (empty),
        .pop    (pop)
    );

    // back end with both sides
    plob_back #(.LEVELS(LEVELS), .TOP_DEPTH(TOP_DEPTH)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .strobe      (strobe),
        .kind        (kind),
        .status      (status),
        .level_side  (level_side),
        .rank        (rank),
        .level_price (level_price),
        .level_size  (level_size),
        .last        (last)
    );

endmodule
